### rtl/core/stick_radial_dead_zone_assert.svh
// Assertion macros shared by the stick dead zone RTL.
// Include with the bare file name; no other dependencies.
`ifndef STICK_RADIAL_DEAD_ZONE_ASSERT_SVH
`define STICK_RADIAL_DEAD_ZONE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SRDZ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define SRDZ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SRDZ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define SRDZ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### rtl/core/srdz_pkg.sv
// Package for the stick radial dead zone: widths, full-scale constant, sideband structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package srdz_pkg;

	// full scale of one axis (1.0)
	localparam int STICK_MAX = 32767;

	localparam int RAW_W    = 16;  // raw axis sample
	localparam int RADIUS_W = 15;  // dead zone radius register
	localparam int AXIS_W   = 15;  // |axis| after clamp
	localparam int SQ_W     = 30;  // square of one axis
	localparam int SUM_W    = 31;  // x^2 + y^2
	localparam int FRAC_W   = 8;   // fraction bits of the magnitude
	localparam int MAG_W    = 24;  // magnitude, isqrt(sum << 16)
	localparam int RAD_W    = 2 * MAG_W;  // radicand
	localparam int REM_W    = MAG_W + 3;  // isqrt partial remainder
	localparam int SPAN_W   = 23;  // clipped magnitude minus radius
	localparam int PA_W     = 30;  // STICK_MAX * |axis|
	localparam int DR_W     = 15;  // STICK_MAX - radius
	localparam int NUM_W    = PA_W + SPAN_W;
	localparam int DEN_W    = MAG_W + DR_W;
	localparam int Q_W      = 15;  // quotient, never above STICK_MAX

	// travels with a sample through the square root pipeline
	typedef struct packed {
		logic                neg_x;
		logic                neg_y;
		logic                in_zone;
		logic [PA_W-1:0]     pa_x;
		logic [PA_W-1:0]     pa_y;
		logic [RADIUS_W-1:0] radius;
		logic [DR_W-1:0]     dr;
	} sqrt_side_t;

	// travels with a sample through the divider pipeline
	typedef struct packed {
		logic neg_x;
		logic neg_y;
		logic in_zone;
		logic zero;
	} div_side_t;

endpackage

`default_nettype wire

### rtl/core/srdz_if.sv
// Valid/ready stream interfaces for the stick dead zone: sample in, result out.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface srdz_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] raw_x;
	logic signed [15:0] raw_y;

	modport source (output valid, output raw_x, output raw_y, input ready);
	modport sink (input valid, input raw_x, input raw_y, output ready);
endinterface

interface srdz_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] out_x;
	logic signed [15:0] out_y;
	logic               active;

	modport source (output valid, output out_x, output out_y, output active, input ready);
	modport sink (input valid, input out_x, input out_y, input active, output ready);
endinterface

`default_nettype wire

### rtl/core/stick_radial_dead_zone.sv
// Top level of the stick radial dead zone: input staging, magnitude and scaling.
// Depends on srdz_pkg, srdz_if, srdz_isqrt, srdz_div and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
`include "stick_radial_dead_zone_assert.svh"

// Radial dead zone for one joystick X/Y sample, fixed point, no state besides
// the radius register. A new sample is taken every clock cycle unless the
// result channel stalls, and each sample gives exactly one result through
// 3 staging stages, 24 square root stages, 2 scaling stages, 15 divider
// stages and the output register. Backpressure on the result
// channel freezes the whole pipeline, so nothing is dropped or repeated; the
// sample channel is ready whenever the output register is empty or is being
// drained. Each axis is clamped to -STICK_MAX. A sample with x^2+y^2 below
// radius^2 gives zero outputs and active = 0. Otherwise the output points along
// (x, y) with length (min(mag, STICK_MAX) - radius) / (STICK_MAX - radius),
// STICK_MAX meaning 1.0, truncated toward zero; mag carries 8 fraction bits.
// Outside the dead zone, a zero magnitude or a radius at full scale gives zero
// outputs with active = 1.
// The radius register must only be written while no transaction is in flight.
module stick_radial_dead_zone (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [srdz_pkg::RADIUS_W-1:0] cfg_wdata,
	srdz_in_if.sink                       sample,
	srdz_out_if.source                    result
);
	import srdz_pkg::*;

	localparam logic signed [RAW_W:0] NEG_MAX  = -((RAW_W+1)'(STICK_MAX));
	localparam logic [RADIUS_W-1:0]   R_MAX    = RADIUS_W'(STICK_MAX);
	localparam logic [MAG_W-1:0]      MAG_FULL = MAG_W'(STICK_MAX) << FRAC_W;
	localparam logic [Q_W-1:0]        Q_MAX    = Q_W'(STICK_MAX);

	// clamp to -STICK_MAX, then take |v|
	function automatic logic [AXIS_W-1:0] clamp_abs(input logic signed [RAW_W-1:0] v);
		logic signed [RAW_W:0] w;
		w = (RAW_W+1)'(v);
		if (w < NEG_MAX) begin
			w = NEG_MAX;
		end
		if (w[RAW_W]) begin
			w = -w;
		end
		return w[AXIS_W-1:0];
	endfunction

	// ---------------------------------------------------------------
	// Global stall: every stage moves only when the output can move.
	// ---------------------------------------------------------------
	logic adv;
	logic out_valid_q;

	assign adv          = !out_valid_q || result.ready;
	assign sample.ready = adv;

	// radius register
	logic [RADIUS_W-1:0] radius_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= '0;
		end else if (cfg_we) begin
			radius_q <= cfg_wdata;
		end
	end

	// ---------------------------------------------------------------
	// S1: clamp, absolute value, saturated radius
	// ---------------------------------------------------------------
	logic                valid_s1;
	logic                neg_x_s1, neg_y_s1;
	logic [AXIS_W-1:0]   ax_s1, ay_s1;
	logic [RADIUS_W-1:0] r_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s1    <= clamp_abs(sample.raw_x);
			ay_s1    <= clamp_abs(sample.raw_y);
			neg_x_s1 <= sample.raw_x[RAW_W-1];
			neg_y_s1 <= sample.raw_y[RAW_W-1];
			r_s1     <= (radius_q > R_MAX) ? R_MAX : radius_q;
		end
	end

	// ---------------------------------------------------------------
	// S2: squares, radius^2, STICK_MAX*|axis|, STICK_MAX - radius
	// ---------------------------------------------------------------
	logic                valid_s2;
	logic                neg_x_s2, neg_y_s2;
	logic [SQ_W-1:0]     sqx_s2, sqy_s2, rr_s2;
	logic [PA_W-1:0]     pa_x_s2, pa_y_s2;
	logic [RADIUS_W-1:0] r_s2;
	logic [DR_W-1:0]     dr_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s2   <= SQ_W'(ax_s1) * SQ_W'(ax_s1);
			sqy_s2   <= SQ_W'(ay_s1) * SQ_W'(ay_s1);
			rr_s2    <= SQ_W'(r_s1) * SQ_W'(r_s1);
			pa_x_s2  <= PA_W'(ax_s1) * PA_W'(STICK_MAX);
			pa_y_s2  <= PA_W'(ay_s1) * PA_W'(STICK_MAX);
			dr_s2    <= DR_W'(R_MAX - r_s1);
			r_s2     <= r_s1;
			neg_x_s2 <= neg_x_s1;
			neg_y_s2 <= neg_y_s1;
		end
	end

	// ---------------------------------------------------------------
	// S3: x^2 + y^2 and the dead zone test
	// ---------------------------------------------------------------
	logic             valid_s3;
	logic [SUM_W-1:0] sum_s3;
	sqrt_side_t       side_s3;
	logic [SUM_W-1:0] sum_c;

	assign sum_c = SUM_W'(sqx_s2) + SUM_W'(sqy_s2);

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s3          <= sum_c;
			side_s3.in_zone <= sum_c < SUM_W'(rr_s2);
			side_s3.neg_x   <= neg_x_s2;
			side_s3.neg_y   <= neg_y_s2;
			side_s3.pa_x    <= pa_x_s2;
			side_s3.pa_y    <= pa_y_s2;
			side_s3.radius  <= r_s2;
			side_s3.dr      <= dr_s2;
		end
	end

	// ---------------------------------------------------------------
	// Magnitude: isqrt(sum << 16), 24 stages
	// ---------------------------------------------------------------
	logic             sq_valid;
	logic [MAG_W-1:0] mag;
	sqrt_side_t       sq_side;

	srdz_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (valid_s3),
		.in_sum   (sum_s3),
		.in_side  (side_s3),
		.out_valid(sq_valid),
		.out_mag  (mag),
		.out_side (sq_side)
	);

	// ---------------------------------------------------------------
	// S4: clip magnitude to full scale, subtract the radius
	// ---------------------------------------------------------------
	logic              valid_s4;
	logic [SPAN_W-1:0] span_s4;
	logic [MAG_W-1:0]  mag_s4;
	logic [PA_W-1:0]   pa_x_s4, pa_y_s4;
	logic [DR_W-1:0]   dr_s4;
	div_side_t         dside_s4;
	logic [MAG_W-1:0]  magc;
	logic [MAG_W-1:0]  rsh;

	assign magc = (mag > MAG_FULL) ? MAG_FULL : mag;
	assign rsh  = MAG_W'(sq_side.radius) << FRAC_W;

	always_ff @(posedge clk) begin
		if (adv) begin
			span_s4          <= (magc >= rsh) ? SPAN_W'(magc - rsh) : '0;
			mag_s4           <= mag;
			pa_x_s4          <= sq_side.pa_x;
			pa_y_s4          <= sq_side.pa_y;
			dr_s4            <= sq_side.dr;
			dside_s4.neg_x   <= sq_side.neg_x;
			dside_s4.neg_y   <= sq_side.neg_y;
			dside_s4.in_zone <= sq_side.in_zone;
			// zero denominator: no magnitude, or radius at full scale
			dside_s4.zero    <= (mag == '0) || (sq_side.dr == '0);
		end
	end

	// ---------------------------------------------------------------
	// S5: numerators and the shared denominator
	// ---------------------------------------------------------------
	logic             valid_s5;
	logic [NUM_W-1:0] num_x_s5, num_y_s5;
	logic [DEN_W-1:0] den_s5;
	div_side_t        dside_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			num_x_s5 <= NUM_W'(pa_x_s4) * NUM_W'(span_s4);
			num_y_s5 <= NUM_W'(pa_y_s4) * NUM_W'(span_s4);
			den_s5   <= DEN_W'(mag_s4) * DEN_W'(dr_s4);
			dside_s5 <= dside_s4;
		end
	end

	// ---------------------------------------------------------------
	// Divide, 15 stages
	// ---------------------------------------------------------------
	logic           div_valid;
	logic [Q_W-1:0] q_x, q_y;
	div_side_t      div_side;

	srdz_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (valid_s5),
		.num_x    (num_x_s5),
		.num_y    (num_y_s5),
		.den      (den_s5),
		.in_side  (dside_s5),
		.out_valid(div_valid),
		.q_x      (q_x),
		.q_y      (q_y),
		.out_side (div_side)
	);

	// ---------------------------------------------------------------
	// Output register: sign, dead zone and zero-denominator override
	// ---------------------------------------------------------------
	logic [RAW_W-1:0] mx, my;
	logic             force_zero;
	logic [RAW_W-1:0] out_x_q, out_y_q;
	logic             active_q;

	assign mx         = RAW_W'(q_x);
	assign my         = RAW_W'(q_y);
	assign force_zero = div_side.in_zone || div_side.zero;

	always_ff @(posedge clk) begin
		if (adv) begin
			out_x_q  <= force_zero ? '0 : (div_side.neg_x ? -mx : mx);
			out_y_q  <= force_zero ? '0 : (div_side.neg_y ? -my : my);
			active_q <= !div_side.in_zone;
		end
	end

	// valid bits of the local stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			valid_s5    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= sample.valid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			valid_s4    <= sq_valid;
			valid_s5    <= valid_s4;
			out_valid_q <= div_valid;
		end
	end

	assign result.valid  = out_valid_q;
	assign result.out_x  = out_x_q;
	assign result.out_y  = out_y_q;
	assign result.active = active_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	`SRDZ_ASSERT_IMP(a_stall_blocks_input, clk, arst_n, result.valid && !result.ready, !sample.ready, "input taken while output stalled")
	`SRDZ_ASSERT_NXT(a_accept_enters_s1, clk, arst_n, sample.valid && sample.ready, valid_s1, "accepted transaction missing in first stage")
	`SRDZ_ASSERT_IMP(a_mag_not_below_radius, clk, arst_n, sq_valid && !sq_side.in_zone, mag >= rsh, "magnitude below radius outside dead zone")
	`SRDZ_ASSERT_IMP(a_quotient_bound, clk, arst_n, div_valid, (q_x <= Q_MAX) && (q_y <= Q_MAX), "quotient above full scale")

endmodule

`default_nettype wire

### rtl/core/srdz_isqrt.sv
// Pipelined integer square root of (sum << 16), one result bit per stage.
// Depends on srdz_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srdz_isqrt (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  logic [srdz_pkg::SUM_W-1:0]     in_sum,
	input  srdz_pkg::sqrt_side_t           in_side,
	output logic                           out_valid,
	output logic [srdz_pkg::MAG_W-1:0]     out_mag,
	output srdz_pkg::sqrt_side_t           out_side
);
	import srdz_pkg::*;

	logic [RAD_W-1:0] rad_s  [MAG_W];
	logic [REM_W-1:0] rem_s  [MAG_W];
	logic [MAG_W-1:0] root_s [MAG_W];
	sqrt_side_t       side_s [MAG_W];
	logic             valid_s[MAG_W];

	logic [RAD_W-1:0] radicand;
	assign radicand = RAD_W'(in_sum) << (2 * FRAC_W);

	for (genvar i = 0; i < MAG_W; i++) begin : g_step
		logic [RAD_W-1:0] rad_in;
		logic [REM_W-1:0] rem_in;
		logic [MAG_W-1:0] root_in;
		sqrt_side_t       side_in;
		logic             valid_in;
		logic [REM_W-1:0] cur;
		logic [REM_W-1:0] trial;

		if (i == 0) begin : g_head
			assign rad_in   = radicand;
			assign rem_in   = '0;
			assign root_in  = '0;
			assign side_in  = in_side;
			assign valid_in = in_valid;
		end else begin : g_tail
			assign rad_in   = rad_s[i-1];
			assign rem_in   = rem_s[i-1];
			assign root_in  = root_s[i-1];
			assign side_in  = side_s[i-1];
			assign valid_in = valid_s[i-1];
		end

		// bring down the next two radicand bits, try root*4+1
		assign cur   = {rem_in[REM_W-3:0], rad_in[RAD_W-1-2*i -: 2]};
		assign trial = REM_W'({root_in, 2'b01});

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[i]  <= rad_in;
				side_s[i] <= side_in;
				if (cur >= trial) begin
					rem_s[i]  <= cur - trial;
					root_s[i] <= {root_in[MAG_W-2:0], 1'b1};
				end else begin
					rem_s[i]  <= cur;
					root_s[i] <= {root_in[MAG_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i] <= 1'b0;
			end else if (en) begin
				valid_s[i] <= valid_in;
			end
		end
	end

	assign out_valid = valid_s[MAG_W-1];
	assign out_mag   = root_s[MAG_W-1];
	assign out_side  = side_s[MAG_W-1];

endmodule

`default_nettype wire

### rtl/core/srdz_div.sv
// Pipelined restoring divider, two numerators over one shared denominator,
// one quotient bit per stage. Depends on srdz_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srdz_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  logic [srdz_pkg::NUM_W-1:0]     num_x,
	input  logic [srdz_pkg::NUM_W-1:0]     num_y,
	input  logic [srdz_pkg::DEN_W-1:0]     den,
	input  srdz_pkg::div_side_t            in_side,
	output logic                           out_valid,
	output logic [srdz_pkg::Q_W-1:0]       q_x,
	output logic [srdz_pkg::Q_W-1:0]       q_y,
	output srdz_pkg::div_side_t            out_side
);
	import srdz_pkg::*;

	logic [NUM_W-1:0] rx_s   [Q_W];
	logic [NUM_W-1:0] ry_s   [Q_W];
	logic [Q_W-1:0]   qx_s   [Q_W];
	logic [Q_W-1:0]   qy_s   [Q_W];
	logic [DEN_W-1:0] den_s  [Q_W];
	div_side_t        side_s [Q_W];
	logic             valid_s[Q_W];

	// quotient fits Q_W bits, so the first trial is den << (Q_W-1)
	for (genvar i = 0; i < Q_W; i++) begin : g_step
		localparam int K = Q_W - 1 - i;

		logic [NUM_W-1:0] rx_in;
		logic [NUM_W-1:0] ry_in;
		logic [Q_W-1:0]   qx_in;
		logic [Q_W-1:0]   qy_in;
		logic [DEN_W-1:0] den_in;
		div_side_t        side_in;
		logic             valid_in;
		logic [NUM_W-1:0] dsh;

		if (i == 0) begin : g_head
			assign rx_in    = num_x;
			assign ry_in    = num_y;
			assign qx_in    = '0;
			assign qy_in    = '0;
			assign den_in   = den;
			assign side_in  = in_side;
			assign valid_in = in_valid;
		end else begin : g_tail
			assign rx_in    = rx_s[i-1];
			assign ry_in    = ry_s[i-1];
			assign qx_in    = qx_s[i-1];
			assign qy_in    = qy_s[i-1];
			assign den_in   = den_s[i-1];
			assign side_in  = side_s[i-1];
			assign valid_in = valid_s[i-1];
		end

		assign dsh = NUM_W'(den_in) << K;

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[i]  <= den_in;
				side_s[i] <= side_in;
				if (rx_in >= dsh) begin
					rx_s[i] <= rx_in - dsh;
					qx_s[i] <= {qx_in[Q_W-2:0], 1'b1};
				end else begin
					rx_s[i] <= rx_in;
					qx_s[i] <= {qx_in[Q_W-2:0], 1'b0};
				end
				if (ry_in >= dsh) begin
					ry_s[i] <= ry_in - dsh;
					qy_s[i] <= {qy_in[Q_W-2:0], 1'b1};
				end else begin
					ry_s[i] <= ry_in;
					qy_s[i] <= {qy_in[Q_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i] <= 1'b0;
			end else if (en) begin
				valid_s[i] <= valid_in;
			end
		end
	end

	assign out_valid = valid_s[Q_W-1];
	assign q_x       = qx_s[Q_W-1];
	assign q_y       = qy_s[Q_W-1];
	assign out_side  = side_s[Q_W-1];

endmodule

`default_nettype wire

### bench/tb_top.sv
// Self-checking bench for stick_radial_dead_zone: corner table, then random phases.
// Depends on srdz_pkg, srdz_in_if / srdz_out_if and the block's RTL.
`timescale 1ns / 1ps

module tb_top;

	import srdz_pkg::*;

	localparam longint          FULL_S          = STICK_MAX;
	localparam longint unsigned FULL_U          = STICK_MAX;
	localparam int              RESET_CYCLES    = 6;
	localparam int              PHASE_ITEMS     = 225;
	localparam int              NUM_PHASES      = 6;
	localparam int              RX_HOLD_CYCLES  = 300;  // well past the 45-deep pipe
	localparam int              TAIL_CYCLES     = 60;   // longer than the pipeline is deep
	localparam int              WATCHDOG_CYCLES = 4000;
	localparam int              NUM_CORNERS     = 25;

	// one result transaction
	typedef struct packed {
		logic signed [15:0] out_x;
		logic signed [15:0] out_y;
		logic               active;
	} conditioned_t;

	// corner sample: radius to run it under, the sample, and a hand-typed
	// result where it is obvious (known = 0 means ask the predictor)
	typedef struct packed {
		logic [RADIUS_W-1:0] radius;
		logic signed [15:0]  x;
		logic signed [15:0]  y;
		logic                known;
		conditioned_t        want;
	} corner_row_t;

	localparam corner_row_t CORNER_SAMPLES [NUM_CORNERS] = '{
		// zero radius: zero magnitude still counts as outside
		'{15'd0,     16'sd0,      16'sd0,      1'b1, '{16'sd0,      16'sd0,      1'b1}},
		// full deflection on each axis, -32768 clamps to -STICK_MAX
		'{15'd0,     16'sd32767,  16'sd0,      1'b1, '{16'sd32767,  16'sd0,      1'b1}},
		'{15'd0,     16'h8000,    16'sd0,      1'b1, '{-16'sd32767, 16'sd0,      1'b1}},
		'{15'd0,     16'sd0,      16'sd32767,  1'b1, '{16'sd0,      16'sd32767,  1'b1}},
		'{15'd0,     16'sd0,      16'h8000,    1'b1, '{16'sd0,      -16'sd32767, 1'b1}},
		'{15'd0,     16'h8000,    16'h8000,    1'b0, '{16'sd0,      16'sd0,      1'b0}},
		'{15'd0,     16'sd32767,  16'sd32767,  1'b0, '{16'sd0,      16'sd0,      1'b0}},
		'{15'd0,     16'sd1,      -16'sd1,     1'b0, '{16'sd0,      16'sd0,      1'b0}},
		'{15'd0,     -16'sd1,     16'sd0,      1'b1, '{-16'sd1,     16'sd0,      1'b1}},
		'{15'd0,     16'sd12345,  -16'sd6789,  1'b0, '{16'sd0,      16'sd0,      1'b0}},
		'{15'd0,     16'h8000,    16'sd32767,  1'b0, '{16'sd0,      16'sd0,      1'b0}},
		// inside the dead zone, and exactly on its edge (span is zero there)
		'{15'd1000,  16'sd0,      16'sd0,      1'b1, '{16'sd0,      16'sd0,      1'b0}},
		'{15'd1000,  16'sd999,    16'sd0,      1'b1, '{16'sd0,      16'sd0,      1'b0}},
		'{15'd1000,  16'sd1000,   16'sd0,      1'b1, '{16'sd0,      16'sd0,      1'b1}},
		'{15'd1000,  16'sd0,      -16'sd1000,  1'b1, '{16'sd0,      16'sd0,      1'b1}},
		'{15'd1000,  16'sd707,    16'sd707,    1'b0, '{16'sd0,      16'sd0,      1'b0}},
		'{15'd1000,  -16'sd20000, 16'sd15000,  1'b0, '{16'sd0,      16'sd0,      1'b0}},
		// radius at full scale: outside gives zeros with active set
		'{15'd32767, 16'sd32767,  16'sd0,      1'b1, '{16'sd0,      16'sd0,      1'b1}},
		'{15'd32767, 16'h8000,    16'h8000,    1'b1, '{16'sd0,      16'sd0,      1'b1}},
		'{15'd32767, 16'sd100,    16'sd100,    1'b1, '{16'sd0,      16'sd0,      1'b0}},
		'{15'd32767, 16'sd32766,  16'sd0,      1'b1, '{16'sd0,      16'sd0,      1'b0}},
		'{15'd32767, 16'sd0,      16'sd0,      1'b1, '{16'sd0,      16'sd0,      1'b0}},
		'{15'd16384, 16'sd32767,  16'sd32767,  1'b0, '{16'sd0,      16'sd0,      1'b0}},
		'{15'd16384, -16'sd100,   16'sd16384,  1'b0, '{16'sd0,      16'sd0,      1'b0}},
		'{15'd16384, 16'h8000,    16'sd1,      1'b0, '{16'sd0,      16'sd0,      1'b0}}
	};

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [RADIUS_W-1:0] cfg_wdata;

	srdz_in_if  sample_if ();
	srdz_out_if result_if ();

	stick_radial_dead_zone u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.sample   (sample_if),
		.result   (result_if)
	);

	conditioned_t        conditioned_q [$];  // results still owed by the block
	conditioned_t        offered_result;     // result of the sample now on the bus
	logic [RADIUS_W-1:0] radius_now;         // what the block's register holds
	int                  mismatch_count;
	int                  stall_cycles;
	bit                  quiet;              // no idling on either side
	bit                  hold_req;           // ask the receiver for one long hold

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Floor square root, one result bit per trial; inputs stay below 2^48.
	function automatic longint unsigned root_floor(longint unsigned n);
		longint unsigned root;
		longint unsigned trial;
		root = 0;
		for (int b = 24; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= n)
				root = trial;
		end
		return root;
	endfunction

	// Expected result of one sample under a given radius.
	function automatic conditioned_t condition_sample(logic signed [15:0] sx,
		logic signed [15:0] sy, logic [RADIUS_W-1:0] radius);
		longint          x;
		longint          y;
		longint unsigned ax, ay, r, sq, mag, magc, span, den, qx, qy;
		conditioned_t    res;
		x = sx;
		y = sy;
		// symmetric reach: -32768 behaves as -STICK_MAX
		if (x < -FULL_S)
			x = -FULL_S;
		if (y < -FULL_S)
			y = -FULL_S;
		// a radius past full scale saturates (15 bits cannot get there)
		r = (radius > FULL_U) ? FULL_U : longint'(radius);
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		sq = ax * ax + ay * ay;
		res = '0;
		if (sq < r * r)
			return res;  // inside the dead zone
		mag  = root_floor(sq << 16);
		magc = (mag > (FULL_U << 8)) ? (FULL_U << 8) : mag;
		span = (magc >= (r << 8)) ? magc - (r << 8) : 0;
		den  = mag * (FULL_U - r);
		// den is zero for a null vector or a full-scale radius: outputs stay 0
		qx = (den == 0) ? 0 : (FULL_U * ax * span) / den;
		qy = (den == 0) ? 0 : (FULL_U * ay * span) / den;
		res.out_x  = (x < 0) ? 16'(-qx) : 16'(qx);
		res.out_y  = (y < 0) ? 16'(-qy) : 16'(qy);
		res.active = 1'b1;
		return res;
	endfunction

	// Offer one sample and hold it until the block takes it.
	task automatic send_sample(logic signed [15:0] x, logic signed [15:0] y,
		conditioned_t want);
		sample_if.valid <= 1'b1;
		sample_if.raw_x <= x;
		sample_if.raw_y <= y;
		offered_result  <= want;
		do
			@(posedge clk);
		while (!sample_if.ready);
	endtask

	// Random sender idle burst, none while quiet.
	task automatic sender_gap();
		if (!quiet && $urandom_range(0, 5) == 0) begin
			sample_if.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// Stop offering and wait until every owed result has come back.
	task automatic drain_results();
		sample_if.valid <= 1'b0;
		@(posedge clk);
		while (conditioned_q.size() != 0)
			@(posedge clk);
	endtask

	// Radius write; only called with the pipe empty.
	task automatic set_radius(logic [RADIUS_W-1:0] r);
		cfg_we    <= 1'b1;
		cfg_wdata <= r;
		@(posedge clk);
		cfg_we     <= 1'b0;
		radius_now  = r;
	endtask

	// Receiver: mostly ready, short random stalls, one long hold on request.
	initial begin : result_sink
		result_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				// long hold-off: the pipe fills and the sample side stalls
				result_if.ready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				hold_req         = 1'b0;
				result_if.ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				result_if.ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
				result_if.ready <= 1'b1;
			end else begin
				result_if.ready <= 1'b1;
			end
		end
	end

	// Scoreboard: results in order against the oldest expectation, and every
	// accepted sample queues its expected result.
	always @(posedge clk) begin : result_check
		conditioned_t want;
		if (arst_n) begin
			if (result_if.valid && result_if.ready) begin
				if (conditioned_q.size() == 0) begin
					$error("result with nothing outstanding: out_x %0d out_y %0d active %0b",
						$signed(result_if.out_x), $signed(result_if.out_y), result_if.active);
					mismatch_count++;
				end else begin
					want = conditioned_q.pop_front();
					if (result_if.out_x !== want.out_x) begin
						$error("out_x: expected %0d, actual %0d",
							$signed(want.out_x), $signed(result_if.out_x));
						mismatch_count++;
					end
					if (result_if.out_y !== want.out_y) begin
						$error("out_y: expected %0d, actual %0d",
							$signed(want.out_y), $signed(result_if.out_y));
						mismatch_count++;
					end
					if (result_if.active !== want.active) begin
						$error("active: expected %0b, actual %0b",
							want.active, result_if.active);
						mismatch_count++;
					end
				end
			end
			if (sample_if.valid && sample_if.ready)
				conditioned_q.push_back(offered_result);
		end
	end

	// Watchdog on cycles with no transaction on either channel.
	always @(posedge clk) begin
		if (!arst_n || (sample_if.valid && sample_if.ready)
			|| (result_if.valid && result_if.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_CYCLES) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin : stimulus
		corner_row_t     row;
		conditioned_t    want;
		longint          r;
		longint          xi;
		longint          yi;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [RADIUS_W-1:0] phase_radius;

		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_wdata       = '0;
		sample_if.valid = 1'b0;
		sample_if.raw_x = '0;
		sample_if.raw_y = '0;
		offered_result  = '0;
		radius_now      = '0;  // register comes out of reset at 0
		mismatch_count  = 0;
		stall_cycles    = 0;
		quiet           = 1'b0;
		hold_req        = 1'b0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner table; the radius is changed only with the pipe empty
		for (int i = 0; i < NUM_CORNERS; i++) begin
			row = CORNER_SAMPLES[i];
			if (row.radius != radius_now) begin
				drain_results();
				set_radius(row.radius);
			end
			want = row.known ? row.want : condition_sample(row.x, row.y, radius_now);
			send_sample(row.x, row.y, want);
			sender_gap();
		end

		// random phases, each under its own radius
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0:       phase_radius = '0;
				1:       phase_radius = RADIUS_W'($urandom_range(1, STICK_MAX - 1));
				2:       phase_radius = RADIUS_W'(STICK_MAX);
				3:       phase_radius = RADIUS_W'(1);
				4:       phase_radius = RADIUS_W'($urandom_range(1, 2000));
				default: phase_radius = RADIUS_W'($urandom_range(0, STICK_MAX));
			endcase
			drain_results();
			set_radius(phase_radius);
			if (phase == 1)
				hold_req = 1'b1;
			if (phase == NUM_PHASES - 1)
				quiet = 1'b1;  // last stretch runs flat out
			r = radius_now;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: begin
						x = 16'($urandom);
						y = 16'($urandom);
					end
					4, 5, 6: begin
						// just inside or outside the dead zone edge
						xi = $urandom_range(0, 32'(r));
						yi = root_floor(r * r - xi * xi) + $urandom_range(0, 4) - 2;
						if (yi < 0)
							yi = 0;
						if (yi > FULL_S)
							yi = FULL_S;
						if ($urandom_range(0, 1))
							xi = -xi;
						if ($urandom_range(0, 1))
							yi = -yi;
						if ($urandom_range(0, 1)) begin
							x = 16'(xi);
							y = 16'(yi);
						end else begin
							x = 16'(yi);
							y = 16'(xi);
						end
					end
					7: begin
						x = $signed(16'($urandom_range(0, 16))) - 16'sd8;
						y = $signed(16'($urandom_range(0, 16))) - 16'sd8;
					end
					default: begin
						// rails and their neighbors
						case ($urandom_range(0, 6))
							0: x = 16'h8000;
							1: x = -16'sd32767;
							2: x = -16'sd1;
							3: x = 16'sd0;
							4: x = 16'sd1;
							5: x = 16'sd32766;
							default: x = 16'sd32767;
						endcase
						case ($urandom_range(0, 6))
							0: y = 16'h8000;
							1: y = -16'sd32767;
							2: y = -16'sd1;
							3: y = 16'sd0;
							4: y = 16'sd1;
							5: y = 16'sd32766;
							default: y = 16'sd32767;
						endcase
					end
				endcase
				send_sample(x, y, condition_sample(x, y, radius_now));
				sender_gap();
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (conditioned_q.size() != 0) begin
			$error("%0d results never arrived", conditioned_q.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### files.f
+incdir+rtl/core
rtl/core/srdz_pkg.sv
rtl/core/srdz_if.sv
rtl/core/srdz_isqrt.sv
rtl/core/srdz_div.sv
rtl/core/stick_radial_dead_zone.sv
bench/tb_top.sv
